// ===== hdl/hgps_pkg.sv =====
// ---------------------------------------------------------------------------
// hgps_pkg
// Shared types and constants of the Henyey-Greenstein phase split core.
// ---------------------------------------------------------------------------
package hgps_pkg;

    // Fixed point constants
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [28:0] INV4PI_Q32 = 29'd341782638;

    // Internal widths
    localparam int X_W    = 32;   // angle in radians, Q30
    localparam int X2_W   = 32;   // x squared, Q30
    localparam int T_W    = 31;   // Horner accumulator, Q30
    localparam int S_W    = 31;   // sine, Q30
    localparam int S2_W   = 32;   // sine squared, Q30
    localparam int AA_W   = 33;   // (1 -/+ g)^2, Q30
    localparam int TERM_W = 35;   // 4 g s^2, Q30
    localparam int D_W    = 36;   // denominator base, Q30
    localparam int R_W    = 32;   // square root result
    localparam int P_W    = 64;   // D^1.5, Q60
    localparam int N_W    = 59;   // numerator, Q62
    localparam int DIV_W  = 96;   // divider remainder
    localparam int OUT_W  = 32;

    // Taylor sine: Horner steps, divisors and 2^32 reciprocals
    localparam int HRN_STEPS = 7;
    localparam logic [7:0] HRN_DIV [HRN_STEPS] = '{
        8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [29:0] HRN_MUL [HRN_STEPS] = '{
        30'd20452225, 30'd27531841, 30'd39045157, 30'd59652323,
        30'd102261126, 30'd214748364, 30'd715827882
    };

    localparam int ROOT_STEPS = 32;
    localparam int DIV_BITS   = 32;

    // Lane depth: front 2, Horner 3 per step, sine 2, denominator 2,
    // root 32, product 2, overflow check 1, divider 32
    localparam int LANE_LAT = 2 + 3 * HRN_STEPS + 2 + 2 + ROOT_STEPS + 2 + 1 + DIV_BITS;

    // Register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT  = 1'd1;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [X2_W-1:0] x2;
        logic [T_W-1:0]  t;
    } t_hrn;

    typedef struct packed {
        logic [63:0]    v;
        logic [63:0]    res;
        logic [D_W-1:0] d;
    } t_root;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [P_W-1:0]   p;
        logic [OUT_W-1:0] q;
        logic             ovf;
    } t_div;

    // Values derived from the asymmetry register
    typedef struct packed {
        logic [15:0]     mag;
        logic            neg;
        logic [AA_W-1:0] aa;
        logic [N_W-1:0]  nn;
        logic            nz;
    } t_gcfg;

endpackage

// ===== hdl/hgps_in_if.sv =====
// ---------------------------------------------------------------------------
// hgps_in_if
// Angle channel: valid/ready handshake carrying one scattering angle.
// ---------------------------------------------------------------------------
interface hgps_in_if #(
    parameter int ANGLE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] scatter_angle;

    modport source (output valid, output scatter_angle, input ready);
    modport sink   (input valid, input scatter_angle, output ready);
endinterface

// ===== hdl/hgps_out_if.sv =====
// ---------------------------------------------------------------------------
// hgps_out_if
// Result channel: valid/ready handshake carrying the three phase values.
// ---------------------------------------------------------------------------
interface hgps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] phase_full;
    logic [31:0] phase_wave;
    logic [31:0] phase_peak;

    modport source (output valid, output phase_full, output phase_wave,
                    output phase_peak, input ready);
    modport sink   (input valid, input phase_full, input phase_wave,
                    input phase_peak, output ready);
endinterface

// ===== hdl/hgps_horner_cell.sv =====
// ---------------------------------------------------------------------------
// hgps_horner_cell
// One Horner step of the sine series: t = 1 - floor(x^2 t / d), three ranks.
// ---------------------------------------------------------------------------
module hgps_horner_cell import hgps_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_hrn i_d,
    output t_hrn o_d
);
    localparam logic [29:0] MUL = HRN_MUL[STEP];
    localparam logic [7:0]  DVS = HRN_DIV[STEP];

    logic [62:0]     r_prod, n_prod;
    logic [X_W-1:0]  r_ax, r_bx;
    logic [X2_W-1:0] r_ax2, r_bx2;
    logic [31:0]     r_y, n_y;
    logic [61:0]     r_m, n_m;
    t_hrn            r_out, n_out;
    logic [29:0]     w_q0;
    logic [37:0]     w_qd, w_rem;
    logic [30:0]     w_q;

    // x^2 t, then reciprocal multiply, then one-step correction
    always_comb begin
        n_prod = 63'(i_d.x2) * 63'(i_d.t);
        n_y    = r_prod[61:30];
        n_m    = 62'(n_y) * 62'(MUL);
        w_q0   = r_m[61:32];
        w_qd   = 38'(w_q0) * 38'(DVS);
        w_rem  = 38'(r_y) - w_qd;
        w_q    = (w_rem >= 38'(DVS)) ? 31'(w_q0) + 31'd1 : 31'(w_q0);
        n_out.x  = r_bx;
        n_out.x2 = r_bx2;
        n_out.t  = ONE_Q30 - w_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_ax   <= i_d.x;
            r_ax2  <= i_d.x2;
            r_y    <= n_y;
            r_m    <= n_m;
            r_bx   <= r_ax;
            r_bx2  <= r_ax2;
            r_out  <= n_out;
        end
    end

    assign o_d = r_out;
endmodule

// ===== hdl/hgps_root_cell.sv =====
// ---------------------------------------------------------------------------
// hgps_root_cell
// One digit of the restoring integer square root.
// ---------------------------------------------------------------------------
module hgps_root_cell import hgps_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_root i_d,
    output t_root o_d
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] w_sum;
    t_root       r_out, n_out;

    // trial subtract of res + bit
    always_comb begin
        w_sum   = i_d.res + BIT;
        n_out.d = i_d.d;
        if (i_d.v >= w_sum) begin
            n_out.v   = i_d.v - w_sum;
            n_out.res = (i_d.res >> 1) + BIT;
        end else begin
            n_out.v   = i_d.v;
            n_out.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_d = r_out;
endmodule

// ===== hdl/hgps_div_cell.sv =====
// ---------------------------------------------------------------------------
// hgps_div_cell
// One quotient bit of the restoring divider.
// ---------------------------------------------------------------------------
module hgps_div_cell import hgps_pkg::*; #(
    parameter int BIT_POS = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);
    logic [DIV_W-1:0] w_sub;
    t_div             r_out, n_out;

    // subtract divisor shifted to this bit when it fits
    always_comb begin
        w_sub = {{(DIV_W-P_W){1'b0}}, i_d.p} << BIT_POS;
        n_out = i_d;
        if (i_d.rem >= w_sub) begin
            n_out.rem = i_d.rem - w_sub;
            n_out.q   = i_d.q | (32'd1 << BIT_POS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_d = r_out;
endmodule

// ===== hdl/hgps_lane.sv =====
// ---------------------------------------------------------------------------
// hgps_lane
// Full phase evaluation of one angle: sine series, denominator, root and
// saturating divide, one angle a cycle while i_en is high, through a chain of cells.
// ---------------------------------------------------------------------------
module hgps_lane import hgps_pkg::*; #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  t_gcfg                 i_g,
    output logic [OUT_W-1:0]      o_phase
);
    localparam logic [ANGLE_BITS:0] HALF    = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS:0] FULL_AN = (ANGLE_BITS+1)'(1) << ANGLE_BITS;

    logic [ANGLE_BITS:0]    w_u;
    logic [ANGLE_BITS+31:0] w_xp;
    logic [63:0]            w_x2p, w_sp, w_s2p;
    logic [47:0]            w_tp;
    logic [D_W-1:0]         w_dd;
    logic [DIV_W-1:0]       w_num;

    logic [X_W-1:0]    r_x;
    t_hrn              r_h0;
    logic [S_W-1:0]    r_s;
    logic [S2_W-1:0]   r_s2;
    logic [TERM_W-1:0] r_term;
    t_root             r_rt;
    logic [51:0]       r_pl, r_ph;
    logic [P_W-1:0]    r_p;
    t_div              r_dv;

    t_hrn  w_h [HRN_STEPS+1];
    t_root w_r [ROOT_STEPS+1];
    t_div  w_v [DIV_BITS+1];

    // fold about pi, scale to radians, square
    always_comb begin
        w_u   = ({1'b0, i_angle} > HALF) ? FULL_AN - {1'b0, i_angle} : {1'b0, i_angle};
        w_xp  = (ANGLE_BITS+32)'(w_u[ANGLE_BITS-1:0]) * (ANGLE_BITS+32)'(PI_Q30);
        w_x2p = 64'(r_x) * 64'(r_x);
        w_sp  = 64'(w_h[HRN_STEPS].x) * 64'(w_h[HRN_STEPS].t);
        w_s2p = 64'(r_s) * 64'(r_s);
        w_tp  = 48'(i_g.mag) * 48'(r_s2);
        if (i_g.neg) begin
            w_dd = ({3'b0, i_g.aa} >= {1'b0, r_term}) ?
                   {3'b0, i_g.aa} - {1'b0, r_term} : '0;
        end else begin
            w_dd = {3'b0, i_g.aa} + {1'b0, r_term};
        end
        w_num = DIV_W'(i_g.nn) << (OUT_FRAC_BITS - 2);
    end

    // front ranks, sine tail and denominator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= w_xp[ANGLE_BITS+31:ANGLE_BITS];
            r_h0.x  <= r_x;
            r_h0.x2 <= w_x2p[61:30];
            r_h0.t  <= ONE_Q30;
            r_s     <= w_sp[60:30];
            r_s2    <= w_s2p[61:30];
            r_term  <= w_tp[47:13];
            r_rt.v  <= {w_dd[33:0], 30'b0};
            r_rt.res <= '0;
            r_rt.d  <= w_dd;
        end
    end

    assign w_h[0] = r_h0;
    for (genvar gi = 0; gi < HRN_STEPS; gi++) begin : g_hrn
        hgps_horner_cell #(.STEP(gi)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_h[gi]),
            .o_d   (w_h[gi+1])
        );
    end

    assign w_r[0] = r_rt;
    for (genvar gi = 0; gi < ROOT_STEPS; gi++) begin : g_root
        hgps_root_cell #(.STEP(gi)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_r[gi]),
            .o_d   (w_r[gi+1])
        );
    end

    // D * sqrt(D) in two halves, then overflow test against 2^32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl     <= 52'(w_r[ROOT_STEPS].d) * 52'(w_r[ROOT_STEPS].res[15:0]);
            r_ph     <= 52'(w_r[ROOT_STEPS].d) * 52'(w_r[ROOT_STEPS].res[31:16]);
            r_p      <= 64'(r_pl) + (64'(r_ph) << 16);
            r_dv.rem <= w_num;
            r_dv.p   <= r_p;
            r_dv.q   <= '0;
            r_dv.ovf <= (w_num >= {r_p, 32'b0});
        end
    end

    assign w_v[0] = r_dv;
    for (genvar gi = 0; gi < DIV_BITS; gi++) begin : g_div
        hgps_div_cell #(.BIT_POS(DIV_BITS - 1 - gi)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_v[gi]),
            .o_d   (w_v[gi+1])
        );
    end

    // zero numerator wins, then saturation
    always_comb begin
        if (!i_g.nz) begin
            o_phase = '0;
        end else if (w_v[DIV_BITS].ovf) begin
            o_phase = '1;
        end else begin
            o_phase = w_v[DIV_BITS].q;
        end
    end
endmodule

// ===== hdl/henyey_greenstein_phase_split_core.sv =====
// Throughput: one angle per cycle, set by the cell chain (sine, root, divider)
// that takes a new word in every cycle; the whole chain stalls only while a
// result word waits on the output. Reset (synchronous, active low) empties
// the pipeline and loads asymmetry 32440 and the default cutoff angle.
// ---------------------------------------------------------------------------
// henyey_greenstein_phase_split_core
// Henyey-Greenstein phase value split into wave and forward peak parts.
// ---------------------------------------------------------------------------
module henyey_greenstein_phase_split_core import hgps_pkg::*; #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] i_cfg_data,
    hgps_in_if.sink               i_in,
    hgps_out_if.source            o_out
);
    localparam logic [ANGLE_BITS-1:0] CUT_RST =
        ANGLE_BITS'((64'd8 << (ANGLE_BITS - 1)) / 64'd180);
    localparam logic [15:0] ASYM_RST = 16'd32440;

    logic [15:0]           r_asym;
    logic [ANGLE_BITS-1:0] r_cut;
    logic [15:0]           r_mag;
    logic                  r_neg;
    logic [31:0]           r_a;
    logic [30:0]           r_num;
    t_gcfg                 r_gc;
    logic [63:0]           w_aap;
    logic [59:0]           w_nnp;
    logic [31:0]           w_magsq;

    logic [LANE_LAT-1:0] r_vld, r_sel;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_full, r_wave, r_peak;
    logic [OUT_W-1:0]    w_full, w_wave, w_wsel;
    logic                w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asym <= ASYM_RST;
            r_cut  <= CUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ASYM: r_asym <= i_cfg_data[15:0];
                CFG_CUT:  r_cut  <= i_cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // terms that follow from g alone, registered through r_mag, r_a and r_gc after a write
    always_comb begin
        w_magsq = 32'(r_mag) * 32'(r_mag);
        w_aap   = 64'(r_a) * 64'(r_a);
        w_nnp   = 60'(r_num) * 60'(INV4PI_Q32);
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= r_asym[15];
        r_mag    <= r_asym[15] ? 16'(-r_asym) : r_asym;
        r_a      <= r_neg ? 32'(ONE_Q30) + (32'(r_mag) << 15)
                          : 32'(ONE_Q30) - (32'(r_mag) << 15);
        r_num    <= ONE_Q30 - w_magsq[30:0];
        r_gc.mag <= r_mag;
        r_gc.neg <= r_neg;
        r_gc.aa  <= w_aap[62:30];
        r_gc.nn  <= w_nnp[N_W-1:0];
        r_gc.nz  <= (r_num != '0);
    end

    // whole chain moves unless a result word is held
    assign w_en        = !r_out_vld || o_out.ready;
    assign i_in.ready  = w_en;

    hgps_lane #(.ANGLE_BITS(ANGLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_full (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.scatter_angle),
        .i_g     (r_gc),
        .o_phase (w_full)
    );

    hgps_lane #(.ANGLE_BITS(ANGLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_wave (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_cut),
        .i_g     (r_gc),
        .o_phase (w_wave)
    );

    // valid and below-cutoff flags travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LANE_LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sel <= {r_sel[LANE_LAT-2:0], (i_in.scatter_angle < r_cut)};
        end
    end

    assign w_wsel = r_sel[LANE_LAT-1] ? w_wave : w_full;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_full <= w_full;
            r_wave <= w_wsel;
            r_peak <= (w_full > w_wsel) ? w_full - w_wsel : '0;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.phase_full = r_full;
    assign o_out.phase_wave = r_wave;
    assign o_out.phase_peak = r_peak;

    // a valid word at the chain end reaches the output when the chain moves
    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LANE_LAT-1]) |=> r_out_vld)
        else $error("chain tail word lost");

    // a stalled chain keeps its valid flags
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid chain moved during stall");

    // at or above cutoff there is no peak part
    a_no_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LANE_LAT-1] && !r_sel[LANE_LAT-1]) |=> (r_peak == '0))
        else $error("peak part above cutoff");

    // wave and peak parts add up to the full value
    a_split_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_peak != '0)) |-> (r_wave + r_peak == r_full))
        else $error("split parts do not sum");
endmodule
